// File: design/fccw_pkg.sv
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared types, codes and helpers for the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fccw_pkg;

	localparam int CMD_W    = 2;
	localparam int BADDR_W  = 13;
	localparam int BYTE_W   = 8;
	localparam int CLU_W    = 12;
	localparam int SECTOR_W = 16;
	localparam int CLASS_W  = 3;
	localparam int IDX_W    = 1;
	localparam int CFG_W    = 16;
	localparam int SPC_W    = 8;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

	localparam logic [IDX_W-1:0] REG_SPC = 1'b0;
	localparam logic [IDX_W-1:0] REG_DAS = 1'b1;

	localparam logic [SPC_W-1:0]    SPC_RESET = 8'd1;
	localparam logic [SECTOR_W-1:0] DAS_RESET = 16'd33;

	localparam logic [CLASS_W-1:0] CLASS_FREE     = 3'd0;
	localparam logic [CLASS_W-1:0] CLASS_RESERVED = 3'd1;
	localparam logic [CLASS_W-1:0] CLASS_LINK     = 3'd2;
	localparam logic [CLASS_W-1:0] CLASS_BAD      = 3'd3;
	localparam logic [CLASS_W-1:0] CLASS_EOC      = 3'd4;

	localparam logic [CLU_W-1:0] LINK_FREE = 12'h000;
	localparam logic [CLU_W-1:0] LINK_RSVD = 12'h001;
	localparam logic [CLU_W-1:0] LINK_MIN  = 12'h002;
	localparam logic [CLU_W-1:0] LINK_MAX  = 12'hff6;
	localparam logic [CLU_W-1:0] LINK_BAD  = 12'hff7;
	localparam logic [3:0]       NIBBLE    = 4'hf;
	localparam logic [CLU_W-1:0] COUNT_MAX = 12'hfff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_RD_LO,
		ST_RD_HI,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	function automatic logic is_link(input logic [CLU_W-1:0] v);
		return (v >= LINK_MIN) && (v <= LINK_MAX);
	endfunction

	function automatic logic [CLASS_W-1:0] link_class_of(input logic [CLU_W-1:0] v);
		logic [CLASS_W-1:0] c;
		if (v == LINK_FREE)
			c = CLASS_FREE;
		else if (v == LINK_RSVD)
			c = CLASS_RESERVED;
		else if (is_link(v))
			c = CLASS_LINK;
		else if (v == LINK_BAD)
			c = CLASS_BAD;
		else
			c = CLASS_EOC;
		return c;
	endfunction

endpackage

// File: design/fccw_if.sv
// ----------------------------------------------------------------------------
// fccw channel interfaces
// Command, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fccw_cmd_if import fccw_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [BADDR_W-1:0]   byte_address;
	logic [BYTE_W-1:0]    byte_value;
	logic [CLU_W-1:0]     start_cluster;

	modport source (output valid, command, byte_address, byte_value, start_cluster,
		input ready);
	modport sink (input valid, command, byte_address, byte_value, start_cluster,
		output ready);
endinterface

interface fccw_res_if import fccw_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CLU_W-1:0]     cluster;
	logic [SECTOR_W-1:0]  first_sector;
	logic [CLASS_W-1:0]   link_class;
	logic                 chain_ended;
	logic [CLU_W-1:0]     chain_length;

	modport source (output valid, cluster, first_sector, link_class, chain_ended,
		chain_length, input ready);
	modport sink (input valid, cluster, first_sector, link_class, chain_ended,
		chain_length, output ready);
endinterface

interface fccw_cfg_if import fccw_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [IDX_W-1:0]     index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/fccw_wrap.sv
// ----------------------------------------------------------------------------
// fccw_wrap
// Two-stage reduction of a byte offset modulo the table size, by reciprocal.
// ----------------------------------------------------------------------------
module fccw_wrap import fccw_pkg::*; #(
	parameter int TABLE_BYTES = 8192,
	parameter int AW = $clog2(TABLE_BYTES)
) (
	input  logic               clk,
	input  logic               load,
	input  logic [BADDR_W-1:0] x,
	output logic [AW-1:0]      r
);

	localparam longint unsigned RECIP = 64'h1_0000_0000 / TABLE_BYTES + 1;
	localparam int RW = $clog2(RECIP + 1);
	localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
	localparam logic [BADDR_W-1:0] SIZE_LOW = BADDR_W'(TABLE_BYTES);

	logic [BADDR_W+RW-1:0] prod;
	logic [BADDR_W-1:0]    q_s1;
	logic [BADDR_W-1:0]    x_s1;
	logic [BADDR_W-1:0]    rem;

	assign prod = x * RECIP_C;

	always_ff @(posedge clk) begin
		if (load) begin
			q_s1 <= BADDR_W'(prod >> 32);
			x_s1 <= x;
		end
	end

	assign rem = x_s1 - BADDR_W'(q_s1 * SIZE_LOW);
	assign r   = AW'(rem);

endmodule

// File: design/fccw_table.sv
// ----------------------------------------------------------------------------
// fccw_table
// Single-port table byte memory, registered read data.
// ----------------------------------------------------------------------------
module fccw_table import fccw_pkg::*; #(
	parameter int TABLE_BYTES = 8192,
	parameter int AW = $clog2(TABLE_BYTES)
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [AW-1:0]     addr,
	input  logic [BYTE_W-1:0] wdata,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [TABLE_BYTES];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we)
			mem[addr] <= wdata;
		else if (ctl.re)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/fat12_cluster_chain_walker.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Follows FAT12 cluster chains through a byte-packed allocation table.
//
// Channels: cmd (sink) takes write, start and step commands; res (source)
// gives one result per command; cfg (sink) writes the cluster size in sectors
// (index 0) and data_area_start (index 1) and is always ready.
// A command is taken only while no other is in progress. A write, or a step
// that finds the chain ended, or an unused command passes through ST_ADDR and
// ST_DONE; a start or advancing step through ST_ADDR, ST_RD_LO, ST_RD_HI and
// ST_DONE: the offset modulo table size is registered, then the two entry
// bytes are read one after the other from the single-port table memory.
// Results sit in an output register; while the receiver stalls the finished
// result is held and the next command waits in the final state.
// Reset clears the chain state (cluster 0, link 0, length 0) and loads the
// register defaults; the table memory is not cleared and must be written
// before it is read.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker import fccw_pkg::*; #(
	parameter int TABLE_BYTES = 8192
) (
	input  logic      clk,
	input  logic      arst_n,
	fccw_cmd_if.sink  cmd,
	fccw_res_if.source res,
	fccw_cfg_if.sink  cfg
);

	localparam int AW = $clog2(TABLE_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_BYTES - 1);

	state_t state_q, state_d;

	logic [SPC_W-1:0]    spc_q;
	logic [SECTOR_W-1:0] das_q;

	logic [CLU_W-1:0] cur_q;
	logic [CLU_W-1:0] link_q;
	logic [CLU_W-1:0] count_q;

	logic [CMD_W-1:0]  cmd_s1;
	logic [CLU_W-1:0]  clu_s1;
	logic              adv_s1;
	logic [BYTE_W-1:0] bval_s1;

	logic [AW-1:0]     addr_q;
	logic [BYTE_W-1:0] lo_q;

	logic                in_xfer;
	logic [CLU_W-1:0]    next_clu;
	logic [BADDR_W-1:0]  off;
	logic [BADDR_W-1:0]  wrap_x;
	logic [AW-1:0]       wrap_r;
	logic [AW-1:0]       addr_hi;
	logic [AW-1:0]       mem_addr;
	logic [BYTE_W-1:0]   mem_rdata;
	mem_ctl_t            mem_ctl;
	logic [CLU_W-1:0]    entry;
	logic [SECTOR_W-1:0] diff;
	logic [SECTOR_W-1:0] sector;
	logic                out_load;
	logic                out_valid_q;
	logic                chain_cmd;

	logic [CLU_W-1:0]    res_cluster_q;
	logic [SECTOR_W-1:0] res_sector_q;
	logic [CLASS_W-1:0]  res_class_q;
	logic                res_ended_q;
	logic [CLU_W-1:0]    res_length_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q <= SPC_RESET;
			das_q <= DAS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SPC: spc_q <= cfg.data[SPC_W-1:0];
				REG_DAS: das_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// command capture
	assign cmd.ready = (state_q == ST_IDLE);
	assign in_xfer   = cmd.valid && cmd.ready;
	assign next_clu  = (cmd.command == CMD_START) ? cmd.start_cluster : link_q;
	assign off       = BADDR_W'(({2'b00, next_clu} + {1'b0, next_clu, 1'b0}) >> 1);
	assign wrap_x    = (cmd.command == CMD_WRITE) ? cmd.byte_address : off;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= cmd.command;
			clu_s1  <= next_clu;
			adv_s1  <= (cmd.command == CMD_START) ||
				((cmd.command == CMD_STEP) && is_link(link_q));
			bval_s1 <= cmd.byte_value;
		end
	end

	fccw_wrap #(
		.TABLE_BYTES(TABLE_BYTES),
		.AW(AW)
	) u_wrap (
		.clk (clk),
		.load(in_xfer),
		.x   (wrap_x),
		.r   (wrap_r)
	);

	assign addr_hi  = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
	assign mem_addr = (state_q == ST_RD_LO) ? addr_hi : wrap_r;

	fccw_table #(
		.TABLE_BYTES(TABLE_BYTES),
		.AW(AW)
	) u_table (
		.clk  (clk),
		.ctl  (mem_ctl),
		.addr (mem_addr),
		.wdata(bval_s1),
		.rdata(mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign chain_cmd = (cmd_s1 == CMD_START) || (cmd_s1 == CMD_STEP);

	always_comb begin
		state_d    = state_q;
		mem_ctl.we = 1'b0;
		mem_ctl.re = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer)
					state_d = ST_ADDR;
			end
			ST_ADDR: begin
				if (cmd_s1 == CMD_WRITE) begin
					mem_ctl.we = 1'b1;
					state_d    = ST_DONE;
				end else if (chain_cmd && adv_s1) begin
					mem_ctl.re = 1'b1;
					state_d    = ST_RD_LO;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RD_LO: begin
				mem_ctl.re = 1'b1;
				state_d    = ST_RD_HI;
			end
			ST_RD_HI: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR)
			addr_q <= wrap_r;
		if (state_q == ST_RD_LO)
			lo_q <= mem_rdata;
	end

	// entry assembly, even clusters low 12 bits, odd clusters high 12 bits
	assign entry = clu_s1[0] ? {mem_rdata, lo_q[7:4]}
		: {mem_rdata[3:0] & NIBBLE, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			link_q  <= '0;
			count_q <= '0;
		end else if (state_q == ST_RD_HI) begin
			cur_q  <= clu_s1;
			link_q <= entry;
			if (cmd_s1 == CMD_START)
				count_q <= CLU_W'(1);
			else if (count_q != COUNT_MAX)
				count_q <= count_q + 1'b1;
		end
	end

	// result register
	assign diff   = SECTOR_W'(cur_q) - SECTOR_W'(2);
	assign sector = SECTOR_W'(diff * {8'b0, spc_q}) + das_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (chain_cmd) begin
				res_cluster_q <= cur_q;
				res_sector_q  <= sector;
				res_class_q   <= link_class_of(link_q);
				res_ended_q   <= !adv_s1;
				res_length_q  <= count_q;
			end else begin
				res_cluster_q <= '0;
				res_sector_q  <= '0;
				res_class_q   <= CLASS_FREE;
				res_ended_q   <= 1'b0;
				res_length_q  <= '0;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.cluster      = res_cluster_q;
	assign res.first_sector = res_sector_q;
	assign res.link_class   = res_class_q;
	assign res.chain_ended  = res_ended_q;
	assign res.chain_length = res_length_q;

endmodule
